// ===== rtl/core/cobsd_pkg.sv =====
// ----------------------------------------------------------------------------
// COBS frame decoder package
// Shared types and constants of the decoder front end and result queue.
// ----------------------------------------------------------------------------
package cobsd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] OUTPUT_LIMIT_RESET = 16'hffff;
  localparam logic [7:0]  CODE_MAX  = 8'hff;
  localparam logic [7:0]  CODE_ZERO = 8'h00;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] ST_OK             = 2'd0;
  localparam logic [1:0] ST_UNEXPECTED_ZERO = 2'd1;
  localparam logic [1:0] ST_READ_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_WRITE_OVERFLOW = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic [15:0] consumed_cnt;
    logic [15:0] produced_cnt;
  } cobsd_result_t;

endpackage

// ===== rtl/core/cobs_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// COBS frame decoder
// Each result is registered in the result queue, whose head drives the output ports.
// Throughput: one encoded byte per cycle while the result queue is not full.
// The four-entry result queue lets input continue while results wait.
// Reset is synchronous: it clears the frame state and the queue and sets
// the output limit to 65535.
// ----------------------------------------------------------------------------
module cobs_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_code_byte,
  input  logic [15:0] in_source_length,
  output logic        empty,
  input  logic        pop,
  output logic        out_kind,
  output logic [7:0]  out_data_byte,
  output logic [1:0]  out_status,
  output logic [15:0] out_consumed_cnt,
  output logic [15:0] out_produced_cnt,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_output_limit
);

  cobsd_pkg::cobsd_result_t front_res;
  cobsd_pkg::cobsd_result_t queue_out;
  logic                     front_valid;
  logic                     item_accept;

  assign cfg_ready   = 1'b1;
  assign item_accept = push && !full;

  cobsd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_accept   (item_accept),
    .code_byte     (in_code_byte),
    .source_length (in_source_length),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_limit     (cfg_output_limit),
    .res_valid     (front_valid),
    .res           (front_res)
  );

  cobsd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (front_valid),
    .wr_data (front_res),
    .rd_en   (pop),
    .rd_data (queue_out),
    .q_full  (full),
    .q_empty (empty)
  );

  assign out_kind         = queue_out.kind;
  assign out_data_byte    = queue_out.data_byte;
  assign out_status       = queue_out.status;
  assign out_consumed_cnt = queue_out.consumed_cnt;
  assign out_produced_cnt = queue_out.produced_cnt;

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !empty)
    else $error("Queue reports full and empty at once.");

  a_data_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == cobsd_pkg::KIND_DATA) |->
      (out_status == cobsd_pkg::ST_OK && out_consumed_cnt == 16'd0 &&
       out_produced_cnt == 16'd0))
    else $error("Data transaction carries status fields.");

  a_error_no_produced: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == cobsd_pkg::KIND_STATUS && out_status != cobsd_pkg::ST_OK)
      |-> (out_produced_cnt == 16'd0 && out_data_byte == 8'd0))
    else $error("Error status carries a produced count or data.");

endmodule

// ===== rtl/core/cobsd_front.sv =====
// ----------------------------------------------------------------------------
// COBS decoder front end
// Accepts encoded bytes, tracks the frame and group counters, checks each
// group against the source length and output limit, and produces at most one
// result record per byte.
// ----------------------------------------------------------------------------
module cobsd_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    item_accept,
  input  logic [7:0]              code_byte,
  input  logic [15:0]             source_length,
  input  logic                    cfg_we,
  input  logic [15:0]             cfg_limit,
  output logic                    res_valid,
  output cobsd_pkg::cobsd_result_t res
);

  logic        in_frame_r,      in_frame_nxt;
  logic [7:0]  group_left_r,    group_left_nxt;
  logic        prev_max_r,      prev_max_nxt;
  logic [15:0] consumed_r,      consumed_nxt;
  logic [15:0] produced_r,      produced_nxt;
  logic [15:0] src_len_r,       src_len_nxt;
  logic [15:0] limit_r;

  logic [16:0] cons_inc;
  logic [16:0] read_need;
  logic [16:0] write_need;
  logic [16:0] prod_base;
  logic        insert;
  logic        emit;
  logic [7:0]  group_len;

  function automatic cobsd_pkg::cobsd_result_t make_status(
    input logic [1:0]  st,
    input logic [15:0] cons,
    input logic [15:0] prod
  );
    cobsd_pkg::cobsd_result_t r;
    r.kind         = cobsd_pkg::KIND_STATUS;
    r.data_byte    = 8'd0;
    r.status       = st;
    r.consumed_cnt = cons;
    r.produced_cnt = prod;
    return r;
  endfunction

  function automatic cobsd_pkg::cobsd_result_t make_data(input logic [7:0] b);
    cobsd_pkg::cobsd_result_t r;
    r.kind         = cobsd_pkg::KIND_DATA;
    r.data_byte    = b;
    r.status       = cobsd_pkg::ST_OK;
    r.consumed_cnt = 16'd0;
    r.produced_cnt = 16'd0;
    return r;
  endfunction

  assign group_len = code_byte - 8'd1;
  assign cons_inc  = {1'b0, consumed_r} + 17'd1;
  assign insert    = in_frame_r && !prev_max_r;
  assign prod_base = in_frame_r ? ({1'b0, produced_r} + {16'd0, insert}) : 17'd0;
  assign read_need = (in_frame_r ? {1'b0, consumed_r} : 17'd0) + {9'd0, code_byte};
  assign write_need = prod_base + {9'd0, group_len};

  always_comb begin
    in_frame_nxt   = in_frame_r;
    group_left_nxt = group_left_r;
    prev_max_nxt   = prev_max_r;
    consumed_nxt   = consumed_r;
    produced_nxt   = produced_r;
    src_len_nxt    = src_len_r;
    emit           = 1'b0;
    res            = make_data(cobsd_pkg::CODE_ZERO);

    if (!in_frame_r) begin
      src_len_nxt = source_length;
      if (source_length == 16'd0) begin
        emit = 1'b1;
        res  = make_status(cobsd_pkg::ST_READ_OVERFLOW, 16'd0, 16'd0);
      end else if (code_byte == cobsd_pkg::CODE_ZERO) begin
        emit = 1'b1;
        res  = make_status(cobsd_pkg::ST_UNEXPECTED_ZERO, 16'd1, 16'd0);
      end else if (read_need > {1'b0, source_length}) begin
        emit = 1'b1;
        res  = make_status(cobsd_pkg::ST_READ_OVERFLOW, 16'd0, 16'd0);
      end else if (write_need > {1'b0, limit_r}) begin
        emit = 1'b1;
        res  = make_status(cobsd_pkg::ST_WRITE_OVERFLOW, 16'd0, 16'd0);
      end else begin
        in_frame_nxt   = 1'b1;
        group_left_nxt = group_len;
        prev_max_nxt   = (code_byte == cobsd_pkg::CODE_MAX);
        consumed_nxt   = 16'd1;
        produced_nxt   = 16'd0;
      end
    end else if (group_left_r != 8'd0) begin
      if (code_byte == cobsd_pkg::CODE_ZERO) begin
        emit = 1'b1;
        res  = make_status(cobsd_pkg::ST_UNEXPECTED_ZERO, cons_inc[15:0], 16'd0);
      end else begin
        emit           = 1'b1;
        res            = make_data(code_byte);
        consumed_nxt   = cons_inc[15:0];
        produced_nxt   = produced_r + 16'd1;
        group_left_nxt = group_left_r - 8'd1;
      end
    end else begin
      if (consumed_r >= src_len_r) begin
        emit = 1'b1;
        res  = make_status(cobsd_pkg::ST_READ_OVERFLOW, 16'd0, 16'd0);
      end else if (code_byte == cobsd_pkg::CODE_ZERO) begin
        emit = 1'b1;
        res  = make_status(cobsd_pkg::ST_OK, cons_inc[15:0], produced_r);
      end else if (insert && (produced_r >= limit_r)) begin
        emit = 1'b1;
        res  = make_status(cobsd_pkg::ST_WRITE_OVERFLOW, 16'd0, 16'd0);
      end else if (read_need > {1'b0, src_len_r}) begin
        emit = 1'b1;
        res  = make_status(cobsd_pkg::ST_READ_OVERFLOW, 16'd0, 16'd0);
      end else if (write_need > {1'b0, limit_r}) begin
        emit = 1'b1;
        res  = make_status(cobsd_pkg::ST_WRITE_OVERFLOW, 16'd0, 16'd0);
      end else begin
        emit           = insert;
        res            = make_data(cobsd_pkg::CODE_ZERO);
        group_left_nxt = group_len;
        prev_max_nxt   = (code_byte == cobsd_pkg::CODE_MAX);
        consumed_nxt   = cons_inc[15:0];
        produced_nxt   = prod_base[15:0];
      end
    end

    if (emit && (res.kind == cobsd_pkg::KIND_STATUS)) begin
      in_frame_nxt   = 1'b0;
      group_left_nxt = 8'd0;
      prev_max_nxt   = 1'b0;
      consumed_nxt   = 16'd0;
      produced_nxt   = 16'd0;
    end
  end

  assign res_valid = item_accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      group_left_r <= 8'd0;
      prev_max_r   <= 1'b0;
      consumed_r   <= 16'd0;
      produced_r   <= 16'd0;
      src_len_r    <= 16'd0;
      limit_r      <= cobsd_pkg::OUTPUT_LIMIT_RESET;
    end else begin
      if (item_accept) begin
        in_frame_r   <= in_frame_nxt;
        group_left_r <= group_left_nxt;
        prev_max_r   <= prev_max_nxt;
        consumed_r   <= consumed_nxt;
        produced_r   <= produced_nxt;
        src_len_r    <= src_len_nxt;
      end
      if (cfg_we) begin
        limit_r <= cfg_limit;
      end
    end
  end

endmodule

// ===== rtl/core/cobsd_queue.sv =====
// ----------------------------------------------------------------------------
// COBS decoder result queue
// Small first-in first-out store that holds result records between the
// front end and the result port, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module cobsd_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  cobsd_pkg::cobsd_result_t wr_data,
  input  logic                     rd_en,
  output cobsd_pkg::cobsd_result_t rd_data,
  output logic                     q_full,
  output logic                     q_empty
);

  cobsd_pkg::cobsd_result_t mem [cobsd_pkg::QUEUE_DEPTH];

  logic [cobsd_pkg::QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [cobsd_pkg::QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [cobsd_pkg::QUEUE_CW-1:0] count_r,  count_nxt;
  logic                           do_wr;
  logic                           do_rd;

  assign q_full  = (count_r == cobsd_pkg::QUEUE_CW'(cobsd_pkg::QUEUE_DEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{(cobsd_pkg::QUEUE_CW-1){1'b0}}, do_wr}
                         - {{(cobsd_pkg::QUEUE_CW-1){1'b0}}, do_rd};
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== bench/tb_cobs_frame_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// COBS frame decoder testbench
// Streams directed and random encoded frames into the decoder, predicts
// every decoded byte and frame status, and checks each popped result in
// order against the prediction while both queue sides idle at random.
// ----------------------------------------------------------------------------
class cobs_scoreboard;
  int unsigned               limit;
  int unsigned               src_len;
  int unsigned               consumed;
  int unsigned               produced;
  int unsigned               group_left;
  bit                        in_frame;
  bit                        prev_max;
  cobsd_pkg::cobsd_result_t  expected_q[$];
  int unsigned               errors;

  function new();
    limit    = 65535;
    src_len  = 0;
    errors   = 0;
    in_frame = 1'b0;
    close_frame();
  endfunction

  function void close_frame();
    in_frame   = 1'b0;
    group_left = 0;
    prev_max   = 1'b0;
    consumed   = 0;
    produced   = 0;
  endfunction

  function void set_limit(logic [15:0] value);
    limit = value;
  endfunction

  function void push_status(logic [1:0] st, int unsigned cons, int unsigned prod);
    cobsd_pkg::cobsd_result_t res;
    res.kind         = cobsd_pkg::KIND_STATUS;
    res.data_byte    = 8'h00;
    res.status       = st;
    res.consumed_cnt = cons[15:0];
    res.produced_cnt = prod[15:0];
    expected_q.push_back(res);
    close_frame();
  endfunction

  function void push_data(logic [7:0] value);
    cobsd_pkg::cobsd_result_t res;
    res.kind         = cobsd_pkg::KIND_DATA;
    res.data_byte    = value;
    res.status       = cobsd_pkg::ST_OK;
    res.consumed_cnt = 16'h0000;
    res.produced_cnt = 16'h0000;
    expected_q.push_back(res);
  endfunction

  function bit group_fails(int unsigned code, int unsigned prod, output logic [1:0] st);
    st = cobsd_pkg::ST_OK;
    if (consumed + code - 1 > src_len) begin
      st = cobsd_pkg::ST_READ_OVERFLOW;
      return 1'b1;
    end
    if (prod + code - 1 > limit) begin
      st = cobsd_pkg::ST_WRITE_OVERFLOW;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void open_group(logic [7:0] code);
    in_frame   = 1'b1;
    group_left = code - 1;
    prev_max   = (code == cobsd_pkg::CODE_MAX);
  endfunction

  function void note_byte(logic [7:0] b, logic [15:0] len);
    logic [1:0]  st;
    int unsigned prod;
    bit          sep;
    if (!in_frame) begin
      src_len  = len;
      consumed = 0;
      produced = 0;
      if (len == 0) begin
        push_status(cobsd_pkg::ST_READ_OVERFLOW, 0, 0);
        return;
      end
      consumed = 1;
      if (b == cobsd_pkg::CODE_ZERO) begin
        push_status(cobsd_pkg::ST_UNEXPECTED_ZERO, consumed, 0);
        return;
      end
      if (group_fails(b, 0, st)) begin
        push_status(st, 0, 0);
        return;
      end
      open_group(b);
      return;
    end
    if (group_left > 0) begin
      consumed++;
      if (b == cobsd_pkg::CODE_ZERO) begin
        push_status(cobsd_pkg::ST_UNEXPECTED_ZERO, consumed, 0);
        return;
      end
      produced++;
      group_left--;
      push_data(b);
      return;
    end
    if (consumed >= src_len) begin
      push_status(cobsd_pkg::ST_READ_OVERFLOW, 0, 0);
      return;
    end
    consumed++;
    if (b == cobsd_pkg::CODE_ZERO) begin
      push_status(cobsd_pkg::ST_OK, consumed, produced);
      return;
    end
    sep  = !prev_max;
    prod = produced;
    if (sep) begin
      if (prod >= limit) begin
        push_status(cobsd_pkg::ST_WRITE_OVERFLOW, 0, 0);
        return;
      end
      prod++;
    end
    if (group_fails(b, prod, st)) begin
      push_status(st, 0, 0);
      return;
    end
    produced = prod;
    open_group(b);
    if (sep) begin
      push_data(cobsd_pkg::CODE_ZERO);
    end
  endfunction

  function void check_result(cobsd_pkg::cobsd_result_t got);
    cobsd_pkg::cobsd_result_t exp_res;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("ERROR: unexpected result: kind %0d data %02h status %0d cons %0d prod %0d",
                 got.kind, got.data_byte, got.status, got.consumed_cnt,
                 got.produced_cnt);
      end
      return;
    end
    exp_res = expected_q.pop_front();
    if (got.kind != exp_res.kind || got.data_byte != exp_res.data_byte ||
        got.status != exp_res.status ||
        got.consumed_cnt != exp_res.consumed_cnt ||
        got.produced_cnt != exp_res.produced_cnt) begin
      errors++;
      if (errors <= 10) begin
        $display("ERROR: expected kind %0d data %02h status %0d cons %0d prod %0d",
                 exp_res.kind, exp_res.data_byte, exp_res.status,
                 exp_res.consumed_cnt, exp_res.produced_cnt);
        $display("       actual   kind %0d data %02h status %0d cons %0d prod %0d",
                 got.kind, got.data_byte, got.status, got.consumed_cnt,
                 got.produced_cnt);
      end
    end
  endfunction
endclass

module tb_cobs_frame_decoder;
  typedef logic [7:0] byte_q_t[$];

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_code_byte = 8'h00;
  logic [15:0] in_source_length = 16'h0000;
  logic        empty;
  logic        pop = 1'b0;
  logic        out_kind;
  logic [7:0]  out_data_byte;
  logic [1:0]  out_status;
  logic [15:0] out_consumed_cnt;
  logic [15:0] out_produced_cnt;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_output_limit = 16'h0000;

  cobs_scoreboard sb = new();
  bit             no_idle = 1'b0;
  int unsigned    items_sent = 0;

  cobs_frame_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_code_byte     (in_code_byte),
    .in_source_length (in_source_length),
    .empty            (empty),
    .pop              (pop),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_status       (out_status),
    .out_consumed_cnt (out_consumed_cnt),
    .out_produced_cnt (out_produced_cnt),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_output_limit (cfg_output_limit)
  );

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic byte_q_t cobs_encode(byte_q_t raw);
    byte_q_t     enc;
    int          code_pos;
    logic [7:0]  code;
    enc.push_back(cobsd_pkg::CODE_ZERO);
    code_pos = 0;
    code     = 8'd1;
    foreach (raw[i]) begin
      if (raw[i] == cobsd_pkg::CODE_ZERO) begin
        enc[code_pos] = code;
        code_pos      = enc.size();
        enc.push_back(cobsd_pkg::CODE_ZERO);
        code          = 8'd1;
      end else begin
        enc.push_back(raw[i]);
        code++;
        if (code == cobsd_pkg::CODE_MAX) begin
          enc[code_pos] = code;
          code_pos      = enc.size();
          enc.push_back(cobsd_pkg::CODE_ZERO);
          code          = 8'd1;
        end
      end
    end
    enc[code_pos] = code;
    enc.push_back(cobsd_pkg::CODE_ZERO);
    return enc;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic [15:0] len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push             <= 1'b1;
    in_code_byte     <= b;
    in_source_length <= len;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_byte(b, len);
    items_sent++;
  endtask

  task automatic send_frame(input byte_q_t enc, input logic [15:0] len);
    foreach (enc[i]) begin
      send_byte(enc[i], (i == 0) ? len : 16'($urandom));
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_output_limit <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_limit(value);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_frame();
    byte_q_t     raw;
    byte_q_t     enc;
    int          n;
    int          zero_pct;
    int          r;
    int          cut;
    logic [15:0] len;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      n = $urandom_range(0, 12);
    end else if (r < 95) begin
      n = $urandom_range(13, 40);
    end else begin
      n = $urandom_range(250, 520);
    end
    zero_pct = (n > 200) ? $urandom_range(0, 1) : $urandom_range(0, 40);
    for (int i = 0; i < n; i++) begin
      raw.push_back(($urandom_range(0, 99) < zero_pct) ? cobsd_pkg::CODE_ZERO :
                    8'($urandom_range(1, 255)));
    end
    enc = cobs_encode(raw);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      enc[$urandom_range(0, enc.size() - 1)] = 8'($urandom);
    end else if (r < 14) begin
      cut = $urandom_range(1, enc.size());
      while (enc.size() > cut) void'(enc.pop_back());
    end else if (r < 18) begin
      for (int i = 0; i < $urandom_range(1, 4); i++) begin
        enc.push_back(8'($urandom));
      end
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      len = 16'(enc.size());
    end else if (r < 82) begin
      len = (enc.size() > 3) ? 16'(enc.size() - $urandom_range(1, 3)) : 16'd1;
    end else if (r < 95) begin
      len = 16'($urandom_range(enc.size(), 65535));
    end else begin
      len = 16'($urandom_range(1, 65535));
    end
    no_idle = ($urandom_range(0, 9) == 0);
    send_frame(enc, len);
    if ($urandom_range(0, 29) == 0) begin
      wait_drained();
    end
  endtask

  initial begin
    int          phase_end;
    int unsigned waited;
    logic [15:0] lim;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h05, 16'd0);
    send_byte(cobsd_pkg::CODE_ZERO, 16'd4);
    send_byte(8'hff, 16'd2);
    send_frame('{8'h03, 8'hff, 8'h80, 8'h02, 8'h7f, 8'h00}, 16'd6);
    send_frame('{8'h03, 8'h01, 8'hfe, 8'h00}, 16'd3);
    send_frame('{8'h03, 8'ha5, 8'h00}, 16'd10);
    send_frame('{8'h01, 8'h01, 8'h00}, 16'hffff);
    write_limit(16'd2);
    send_frame('{8'h04, 8'h11, 8'h22, 8'h33}, 16'd20);
    send_frame('{8'h03, 8'haa, 8'h55, 8'h01, 8'h00}, 16'd20);
    write_limit(16'd0);
    send_frame('{8'h01, 8'h00}, 16'd2);
    write_limit(16'hffff);
    send_frame('{8'h02, 8'h5a}, 16'd10);
    write_limit(16'd1);
    send_frame('{8'h02, 8'hc3}, 16'd10);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: lim = 16'hffff;
        1: lim = 16'($urandom_range(0, 24));
        2: lim = 16'd0;
        3: lim = 16'($urandom);
        4: lim = 16'($urandom_range(250, 520));
        default: lim = 16'hffff;
      endcase
      write_limit(lim);
      phase_end = items_sent + 300;
      while (items_sent < phase_end) random_frame();
    end

    push    <= 1'b0;
    no_idle = 1'b0;
    waited  = 0;
    while (sb.expected_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    int                       gap;
    cobsd_pkg::cobsd_result_t got;
    wait (rst_n);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      if (!empty) begin
        got = {out_kind, out_data_byte, out_status, out_consumed_cnt,
               out_produced_cnt};
        sb.check_result(got);
      end
    end
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
